// File: design/fhb_pkg.sv
// Shared types, constants and microcode table of the FIR plus high-pass biquad unit.
package fhb_pkg;

  localparam int ACC_W  = 66;
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int UPC_W  = 5;

  typedef logic [UPC_W-1:0] upc_t;

  // microprogram step addresses
  localparam upc_t U_CLEAR  = 5'd0;
  localparam upc_t U_IDLE   = 5'd1;
  localparam upc_t U_FIR    = 5'd2;
  localparam upc_t U_FDRN0  = 5'd3;
  localparam upc_t U_FDRN1  = 5'd4;
  localparam upc_t U_RND_X  = 5'd5;
  localparam upc_t U_FB_A1  = 5'd6;
  localparam upc_t U_FB_A2  = 5'd7;
  localparam upc_t U_WDRN0  = 5'd8;
  localparam upc_t U_WDRN1  = 5'd9;
  localparam upc_t U_RND_W  = 5'd10;
  localparam upc_t U_FF_B1  = 5'd11;
  localparam upc_t U_FF_B2  = 5'd12;
  localparam upc_t U_YDRN0  = 5'd13;
  localparam upc_t U_YDRN1  = 5'd14;
  localparam upc_t U_WAIT   = 5'd15;
  localparam upc_t U_EMIT   = 5'd16;

  // biquad constants, Q2.30; feedback terms stored negated so every term adds
  localparam logic signed [MUL_W-1:0] BQ_ONE    = 32'sd1073741824;
  localparam logic signed [MUL_W-1:0] BQ_NEG_A1 = 32'sd2127607086;
  localparam logic signed [MUL_W-1:0] BQ_NEG_A2 = -32'sd1054047555;
  localparam logic signed [MUL_W-1:0] BQ_B0     = 32'sd1063849116;
  localparam logic signed [MUL_W-1:0] BQ_B1     = -32'sd2127698232;
  localparam logic signed [MUL_W-1:0] BQ_B2     = 32'sd1063849116;

  // rounding offsets for the Q.20 and Q.30 scale-downs
  localparam logic signed [ACC_W-1:0] HALF_X = ACC_W'(1 << 19);
  localparam logic signed [ACC_W-1:0] HALF_W = ACC_W'(1 << 29);

  typedef enum logic [2:0] {A_DLY, A_X, A_W, A_S0, A_S1} a_sel_e;
  typedef enum logic [2:0] {B_TAP, B_ONE, B_NA1, B_NA2, B_B0, B_B1, B_B2} b_sel_e;
  typedef enum logic [1:0] {MAC_NONE, MAC_LOAD, MAC_ADD} mac_op_e;
  typedef enum logic [2:0] {C_NEXT, C_ALWAYS, C_CNT_MORE, C_NO_SAMPLE, C_OUT_BUSY} cond_e;
  typedef enum logic [2:0] {ACT_NONE, ACT_CLEAR, ACT_FIR, ACT_RND_X, ACT_RND_W, ACT_EMIT} act_e;

  typedef struct packed {
    logic    take;
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    mac_op_e mac_op;
    act_e    act;
    cond_e   cond;
    upc_t    target;
  } uword_t;

  typedef struct packed {
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    mac_op_e mac_op;
  } mac_ctl_t;

  // control store: one word per step, jump to target when cond holds
  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '{take: 1'b0, a_sel: A_DLY, b_sel: B_TAP, mac_op: MAC_NONE,
          act: ACT_NONE, cond: C_NEXT, target: U_IDLE};
    unique case (pc)
      U_CLEAR: begin
        w.act    = ACT_CLEAR;
        w.cond   = C_CNT_MORE;
        w.target = U_CLEAR;
      end
      U_IDLE: begin
        w.take   = 1'b1;
        w.cond   = C_NO_SAMPLE;
        w.target = U_IDLE;
      end
      U_FIR: begin
        w.a_sel  = A_DLY;
        w.b_sel  = B_TAP;
        w.mac_op = MAC_ADD;
        w.act    = ACT_FIR;
        w.cond   = C_CNT_MORE;
        w.target = U_FIR;
      end
      U_FDRN0, U_FDRN1, U_WDRN0, U_WDRN1, U_YDRN0, U_YDRN1: begin
        w.cond = C_NEXT;
      end
      U_RND_X: begin
        w.act    = ACT_RND_X;
        w.a_sel  = A_X;
        w.b_sel  = B_ONE;
        w.mac_op = MAC_LOAD;
      end
      U_FB_A1: begin
        w.a_sel  = A_S0;
        w.b_sel  = B_NA1;
        w.mac_op = MAC_ADD;
      end
      U_FB_A2: begin
        w.a_sel  = A_S1;
        w.b_sel  = B_NA2;
        w.mac_op = MAC_ADD;
      end
      U_RND_W: begin
        w.act    = ACT_RND_W;
        w.a_sel  = A_W;
        w.b_sel  = B_B0;
        w.mac_op = MAC_LOAD;
      end
      U_FF_B1: begin
        w.a_sel  = A_S0;
        w.b_sel  = B_B1;
        w.mac_op = MAC_ADD;
      end
      U_FF_B2: begin
        w.a_sel  = A_S1;
        w.b_sel  = B_B2;
        w.mac_op = MAC_ADD;
      end
      U_WAIT: begin
        w.cond   = C_OUT_BUSY;
        w.target = U_WAIT;
      end
      U_EMIT: begin
        w.act    = ACT_EMIT;
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: design/fir_then_highpass_biquad_unit.sv
// Top level: microcoded FIR filter followed by a fixed 100 Hz high-pass biquad.
//
// Each request is either a coefficient load (req_type_i = 1), which writes one FIR tap and
// returns nothing, or an audio sample (req_type_i = 0), which returns one filtered,
// saturated Q1.15 sample with a clip flag. After reset the block first runs a clearing
// pass over all TAP_COUNT entries (delay line to zero, taps to a unit impulse) and takes
// no request until it is done. A sample runs through the whole filter before the next
// request is taken; each run's length is set by the single shared multiplier-accumulator:
// the FIR issues one tap per cycle, reading the coefficient and delay-line memories once
// per tap, then the biquad issues six more products through the same unit, with pipeline
// drain steps between dependent rounds. A finished result waits in an output register, so
// the next request is taken while it is still pending; only the result of the following
// sample stalls until the register is free. Loads to a tap at or beyond TAP_COUNT are
// dropped. Coefficients wrap to COEF_BITS; when 1.0 does not fit in COEF_BITS the reset
// tap 0 holds the largest positive value instead.
module fir_then_highpass_biquad_unit #(
  parameter int TAP_COUNT = 128,
  parameter int COEF_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [6:0]         tap_index_i,
  input  logic signed [23:0] coef_value_i,
  input  logic signed [15:0] sample_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_out_o,
  output logic               clipped_o
);
  import fhb_pkg::*;

  localparam int AW = $clog2(TAP_COUNT);
  localparam logic [AW-1:0] LAST = AW'(TAP_COUNT - 1);
  // 1.0 in Q.20, or the largest positive code when the store is too narrow for it
  localparam logic signed [COEF_BITS-1:0] COEF_ONE =
    (COEF_BITS > 21) ? COEF_BITS'(1 << 20) : {1'b0, {(COEF_BITS-1){1'b1}}};

  // sequencer and control state
  upc_t          pc_q, pc_d;
  uword_t        uw;
  logic          jump;
  logic [AW-1:0] cnt_q, head_q, rd_ptr_q, head_nxt;
  logic          out_valid_q;
  mac_ctl_t      p1_q;          // operand-select stage
  mac_op_e       p2_op_q;       // accumulate stage
  logic signed [31:0] s0_q, s1_q;

  // request decode
  logic in_acc, smp_acc, ld_hit;

  // memories
  logic signed [15:0]          dly_mem [TAP_COUNT];
  logic signed [COEF_BITS-1:0] tap_mem [TAP_COUNT];
  logic signed [15:0]          dly_rd_q;
  logic signed [COEF_BITS-1:0] tap_rd_q;
  logic                        dly_we, tap_we, clr_step;
  logic [AW-1:0]               dly_wa, tap_wa;
  logic signed [15:0]          dly_wd;
  logic signed [COEF_BITS-1:0] tap_wd;

  // datapath
  logic signed [MUL_W-1:0]  a_op, b_op;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, rnd20, rnd30;
  logic signed [31:0]       x_q, w_q, x_sat, w_sat;
  logic signed [15:0]       y_sat, sample_out_q;
  logic                     x_fit, w_fit, y_fit, clip_q, clipped_q;

  assign uw         = ucode(pc_q);
  assign in_ready_o = uw.take;
  assign in_acc     = in_valid_i & uw.take;
  assign smp_acc    = in_acc & ~req_type_i;
  // tap_index_i is 7 bits wide, so taps from 128 up are never written
  assign ld_hit     = in_acc & req_type_i & ({25'd0, tap_index_i} < 32'(TAP_COUNT));
  assign head_nxt   = (head_q == LAST) ? '0 : head_q + 1'b1;

  always_comb begin
    case (uw.cond)
      C_NEXT:      jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_CNT_MORE:  jump = (cnt_q != LAST);
      C_NO_SAMPLE: jump = ~smp_acc;
      C_OUT_BUSY:  jump = out_valid_q;
      default:     jump = 1'b0;
    endcase
    pc_d = jump ? uw.target : pc_q + 1'b1;
  end

  // memory write ports: the clearing pass, a new sample, a coefficient load
  assign clr_step = (uw.act == ACT_CLEAR);
  assign dly_we   = clr_step | smp_acc;
  assign dly_wa   = clr_step ? cnt_q : head_nxt;
  assign dly_wd   = clr_step ? '0 : sample_in_i;
  assign tap_we   = clr_step | ld_hit;
  assign tap_wa   = clr_step ? cnt_q : AW'(tap_index_i);
  assign tap_wd   = clr_step ? ((cnt_q == '0) ? COEF_ONE : '0) : COEF_BITS'(coef_value_i);

  // delay line as a circular buffer; head_q points at the newest sample
  always_ff @(posedge clk_i) begin
    if (dly_we) begin
      dly_mem[dly_wa] <= dly_wd;
    end
    dly_rd_q <= dly_mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      tap_mem[tap_wa] <= tap_wd;
    end
    tap_rd_q <= tap_mem[cnt_q];
  end

  // sequencer, pointers, MAC control pipeline, biquad state, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= U_CLEAR;
      cnt_q       <= '0;
      head_q      <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
      p1_q        <= '{a_sel: A_DLY, b_sel: B_TAP, mac_op: MAC_NONE};
      p2_op_q     <= MAC_NONE;
      s0_q        <= '0;
      s1_q        <= '0;
    end else begin
      pc_q    <= pc_d;
      p1_q    <= '{a_sel: uw.a_sel, b_sel: uw.b_sel, mac_op: uw.mac_op};
      p2_op_q <= p1_q.mac_op;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (smp_acc) begin
        head_q   <= head_nxt;
        rd_ptr_q <= head_nxt;
      end
      unique case (uw.act)
        ACT_CLEAR: begin
          cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
        end
        ACT_FIR: begin
          cnt_q    <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
          rd_ptr_q <= (rd_ptr_q == '0) ? LAST : rd_ptr_q - 1'b1;
        end
        ACT_EMIT: begin
          out_valid_q <= 1'b1;
          s1_q        <= s0_q;
          s0_q        <= w_q;
        end
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (p1_q.a_sel)
      A_DLY:   a_op = MUL_W'(dly_rd_q);
      A_X:     a_op = x_q;
      A_W:     a_op = w_q;
      A_S0:    a_op = s0_q;
      A_S1:    a_op = s1_q;
      default: a_op = '0;
    endcase
    case (p1_q.b_sel)
      B_TAP:   b_op = MUL_W'(tap_rd_q);
      B_ONE:   b_op = BQ_ONE;
      B_NA1:   b_op = BQ_NEG_A1;
      B_NA2:   b_op = BQ_NEG_A2;
      B_B0:    b_op = BQ_B0;
      B_B1:    b_op = BQ_B1;
      B_B2:    b_op = BQ_B2;
      default: b_op = '0;
    endcase
  end

  // round half up, then saturate; a value fits when its upper bits are all sign
  always_comb begin
    rnd20 = (acc_q + HALF_X) >>> 20;
    rnd30 = (acc_q + HALF_W) >>> 30;
    x_fit = (&rnd20[ACC_W-1:31]) | ~(|rnd20[ACC_W-1:31]);
    w_fit = (&rnd30[ACC_W-1:31]) | ~(|rnd30[ACC_W-1:31]);
    y_fit = (&rnd30[ACC_W-1:15]) | ~(|rnd30[ACC_W-1:15]);
    x_sat = x_fit ? rnd20[31:0] : (rnd20[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    w_sat = w_fit ? rnd30[31:0] : (rnd30[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    y_sat = y_fit ? rnd30[15:0] : (rnd30[ACC_W-1] ? 16'h8000 : 16'h7FFF);
  end

  // multiplier, accumulator and result registers
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_op) * PROD_W'(b_op);
    if (smp_acc) begin
      acc_q  <= '0;
      clip_q <= 1'b0;
    end else begin
      case (p2_op_q)
        MAC_LOAD: acc_q <= ACC_W'(prod_q);
        MAC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
        default:  ;
      endcase
      case (uw.act)
        ACT_RND_X: begin
          x_q    <= x_sat;
          clip_q <= clip_q | ~x_fit;
        end
        ACT_RND_W: begin
          w_q    <= w_sat;
          clip_q <= clip_q | ~w_fit;
        end
        ACT_EMIT: begin
          sample_out_q <= y_sat;
          clipped_q    <= clip_q | ~y_fit;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;

endmodule

// File: design/fhb_checker.sv
// Port-level checker for the FIR plus high-pass biquad unit, with its bind.
module fhb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               req_type_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] sample_out_o,
  input logic               clipped_o
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o) && $stable(clipped_o))
    else $error("pending result changed before it was taken");

  // a sample request starts the filter run, so no request is taken next cycle
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !req_type_i |=> !in_ready_o)
    else $error("request taken right after a sample");

  // a coefficient load leaves the unit ready to take another request
  a_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && req_type_i |=> in_ready_o)
    else $error("not ready right after a coefficient load");

  // a new result only appears at the end of a run, never while idle
  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while the unit was idle");

endmodule

bind fir_then_highpass_biquad_unit fhb_checker u_fhb_checker (.*);
